### rtl/core/hnip_pkg.sv
// ----------------------------------------------------------------------------
// hnip_pkg
// Shared types, codes and tables of the NAL header parser.
// ----------------------------------------------------------------------------
package hnip_pkg;

  localparam int unsigned PREFIX_BYTES_DEF = 4;
  localparam int unsigned FIFO_DEPTH_DEF   = 4;

  localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
  localparam logic [7:0] AUD_INTRA_BYTE = 8'h10;
  localparam logic [7:0] ESC_BYTE       = 8'h03;
  localparam logic [7:0] AR_EXTENDED    = 8'hFF;

  localparam logic [4:0] NAL_TYPE_NONIDR = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR    = 5'd5;
  localparam logic [4:0] NAL_SPS         = 5'd7;
  localparam logic [4:0] NAL_AUD         = 5'd9;

  localparam logic [7:0] PROF_HIGH      = 8'd100;
  localparam logic [7:0] PROF_HIGH10    = 8'd110;
  localparam logic [7:0] PROF_HIGH422   = 8'd122;
  localparam logic [7:0] PROF_HIGH444   = 8'd244;
  localparam logic [7:0] PROF_CAVLC444  = 8'd44;
  localparam logic [7:0] PROF_SCALABLE  = 8'd83;
  localparam logic [7:0] PROF_SCAL_HIGH = 8'd86;

  localparam logic [15:0] RES_1920 = 16'd1920;
  localparam logic [15:0] RES_1280 = 16'd1280;
  localparam logic [15:0] RES_960  = 16'd960;
  localparam logic [15:0] RES_1080 = 16'd1080;
  localparam logic [15:0] RES_720  = 16'd720;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_HDR,
    KIND_DATA
  } hnip_kind_e;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_OTHER,
    MODE_AUD,
    MODE_SLICE,
    MODE_SPS
  } hnip_mode_e;

  typedef struct packed {
    hnip_kind_e kind;
    logic       last;
    hnip_mode_e mode;
    logic       aud_intra;
    logic [7:0] data;
  } hnip_entry_t;

  typedef struct packed {
    logic        frame_start;
    logic        intra_picture;
    logic        sps_updated;
    logic        interlaced;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic        aspect_updated;
    logic [15:0] aspect_num;
    logic [15:0] aspect_den;
    logic        rate_updated;
    logic [31:0] frame_rate_x2;
  } hnip_result_t;

  function automatic logic [7:0] sar_num(input logic [4:0] idc);
    logic [7:0] r;
    unique case (idc)
      5'd1:  r = 8'd1;
      5'd2:  r = 8'd12;
      5'd3:  r = 8'd10;
      5'd4:  r = 8'd16;
      5'd5:  r = 8'd40;
      5'd6:  r = 8'd24;
      5'd7:  r = 8'd20;
      5'd8:  r = 8'd32;
      5'd9:  r = 8'd80;
      5'd10: r = 8'd18;
      5'd11: r = 8'd15;
      5'd12: r = 8'd64;
      5'd13: r = 8'd160;
      5'd14: r = 8'd4;
      5'd15: r = 8'd3;
      5'd16: r = 8'd2;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sar_den(input logic [4:0] idc);
    logic [7:0] r;
    unique case (idc)
      5'd1:  r = 8'd1;
      5'd2:  r = 8'd11;
      5'd3:  r = 8'd11;
      5'd4:  r = 8'd11;
      5'd5:  r = 8'd33;
      5'd6:  r = 8'd11;
      5'd7:  r = 8'd11;
      5'd8:  r = 8'd11;
      5'd9:  r = 8'd33;
      5'd10: r = 8'd11;
      5'd11: r = 8'd11;
      5'd12: r = 8'd33;
      5'd13: r = 8'd99;
      5'd14: r = 8'd3;
      5'd15: r = 8'd2;
      5'd16: r = 8'd1;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/hnip_if.sv
// ----------------------------------------------------------------------------
// hnip interfaces
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface hnip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, packet_byte, first_of_packet, last_of_packet, input ready);
  modport sink (input valid, packet_byte, first_of_packet, last_of_packet, output ready);
endinterface

interface hnip_out_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic        intra_picture;
  logic        sps_updated;
  logic        interlaced;
  logic [15:0] pic_width;
  logic [15:0] pic_height;
  logic        aspect_updated;
  logic [15:0] aspect_num;
  logic [15:0] aspect_den;
  logic        rate_updated;
  logic [31:0] frame_rate_x2;

  modport source (output valid, frame_start, intra_picture, sps_updated, interlaced,
                  pic_width, pic_height, aspect_updated, aspect_num, aspect_den,
                  rate_updated, frame_rate_x2, input ready);
  modport sink (input valid, frame_start, intra_picture, sps_updated, interlaced,
                pic_width, pic_height, aspect_updated, aspect_num, aspect_den,
                rate_updated, frame_rate_x2, output ready);
endinterface

### rtl/core/hnip_front.sv
// ----------------------------------------------------------------------------
// hnip_front
// Byte framing: start code, NAL header, escape removal, delimiter payload.
// ----------------------------------------------------------------------------
module hnip_front #(
  parameter int unsigned PrefixBytes = hnip_pkg::PREFIX_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hnip_in_if.sink              pkt_i,
  input  logic                 full_i,
  output logic                 push_o,
  output hnip_pkg::hnip_entry_t entry_o
);

  localparam int unsigned CntW = $clog2(PrefixBytes + 2);
  localparam logic [CntW-1:0] PrefixCnt = CntW'(PrefixBytes);

  logic                 in_pkt_q, in_pkt_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  hnip_pkg::hnip_mode_e mode_q, mode_d;
  logic                 seen_q, seen_d;
  logic                 intra_q, intra_d;
  logic [1:0]           zr_q, zr_d;
  logic                 accept;
  logic [4:0]           nal_type;

  assign pkt_i.ready = !full_i;
  assign accept      = pkt_i.valid && pkt_i.ready;
  assign nal_type    = 5'(pkt_i.packet_byte & hnip_pkg::NAL_TYPE_MASK);

  always_comb begin
    in_pkt_d = in_pkt_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    seen_d   = seen_q;
    intra_d  = intra_q;
    zr_d     = zr_q;
    push_o   = 1'b0;
    entry_o  = '{kind: hnip_pkg::KIND_NONE, last: 1'b0, mode: hnip_pkg::MODE_NONE,
                 aud_intra: 1'b0, data: pkt_i.packet_byte};
    if (accept) begin
      if (pkt_i.first_of_packet) begin
        in_pkt_d = 1'b1;
        cnt_d    = '0;
        mode_d   = hnip_pkg::MODE_NONE;
        seen_d   = 1'b0;
        intra_d  = 1'b0;
        zr_d     = '0;
      end
      if (in_pkt_d) begin
        if (cnt_d < PrefixCnt) begin
          // start code: drop
        end else if (cnt_d == PrefixCnt) begin
          if (nal_type == hnip_pkg::NAL_AUD) begin
            mode_d = hnip_pkg::MODE_AUD;
          end else if (nal_type == hnip_pkg::NAL_TYPE_NONIDR ||
                       nal_type == hnip_pkg::NAL_TYPE_IDR) begin
            mode_d        = hnip_pkg::MODE_SLICE;
            entry_o.kind  = hnip_pkg::KIND_HDR;
          end else if (nal_type == hnip_pkg::NAL_SPS) begin
            mode_d        = hnip_pkg::MODE_SPS;
            entry_o.kind  = hnip_pkg::KIND_HDR;
          end else begin
            mode_d = hnip_pkg::MODE_OTHER;
          end
        end else if (mode_d == hnip_pkg::MODE_AUD) begin
          if (!seen_d) begin
            seen_d  = 1'b1;
            intra_d = (pkt_i.packet_byte == hnip_pkg::AUD_INTRA_BYTE);
          end
        end else if (mode_d == hnip_pkg::MODE_SLICE || mode_d == hnip_pkg::MODE_SPS) begin
          if (zr_d == 2'd2 && pkt_i.packet_byte == hnip_pkg::ESC_BYTE) begin
            zr_d = '0;
          end else begin
            if (pkt_i.packet_byte != 8'd0) zr_d = '0;
            else if (zr_d != 2'd2) zr_d = zr_d + 2'd1;
            entry_o.kind = hnip_pkg::KIND_DATA;
          end
        end
        if (cnt_d <= PrefixCnt) cnt_d = cnt_d + 1'b1;
        entry_o.mode      = mode_d;
        entry_o.aud_intra = seen_d && intra_d;
        if (pkt_i.last_of_packet) begin
          entry_o.last = 1'b1;
          in_pkt_d     = 1'b0;
        end
        push_o = (entry_o.kind != hnip_pkg::KIND_NONE) || entry_o.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      cnt_q    <= '0;
      mode_q   <= hnip_pkg::MODE_NONE;
      seen_q   <= 1'b0;
      intra_q  <= 1'b0;
      zr_q     <= '0;
    end else begin
      in_pkt_q <= in_pkt_d;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
      seen_q   <= seen_d;
      intra_q  <= intra_d;
      zr_q     <= zr_d;
    end
  end

endmodule

### rtl/core/hnip_fifo.sv
// ----------------------------------------------------------------------------
// hnip_fifo
// Short request queue between framing and bit parsing.
// ----------------------------------------------------------------------------
module hnip_fifo #(
  parameter int unsigned Depth = hnip_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hnip_pkg::hnip_entry_t wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output hnip_pkg::hnip_entry_t rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hnip_pkg::hnip_entry_t mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

### rtl/core/hnip_back.sv
// ----------------------------------------------------------------------------
// hnip_back
// Bit-serial Exp-Golomb syntax walk, rate divider and result register.
// ----------------------------------------------------------------------------
module hnip_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  hnip_pkg::hnip_entry_t entry_i,
  output logic                  pop_o,
  hnip_out_if.source            res_o
);

  localparam logic [6:0] P_IDLE = 7'd0, P_DONE = 7'd1,
    S_PROFILE = 7'd2, S_CONSTR = 7'd3, S_LEVEL = 7'd4, S_SPSID = 7'd5, S_CHROMA = 7'd6,
    S_SEPF = 7'd7, S_BDL = 7'd8, S_BDC = 7'd9, S_QPB = 7'd10, S_SMPF = 7'd11,
    S_SLPF = 7'd12, S_DELTA = 7'd13, S_LOG2 = 7'd14, S_POCT = 7'd15, S_POCLSB = 7'd16,
    S_DPAZ = 7'd17, S_OFF1 = 7'd18, S_OFF2 = 7'd19, S_NCYC = 7'd20, S_CYC = 7'd21,
    S_NREF = 7'd22, S_GAPS = 7'd23, S_WIDTH = 7'd24, S_HEIGHT = 7'd25, S_FMO = 7'd26,
    S_MBAFF = 7'd27, S_D8 = 7'd28, S_CROPF = 7'd29, S_CL = 7'd30, S_CR = 7'd31,
    S_CT = 7'd32, S_CB = 7'd33, S_VUIF = 7'd34, S_ARP = 7'd35, S_ARIDC = 7'd36,
    S_SARW = 7'd37, S_SARH = 7'd38, S_OVSP = 7'd39, S_OVSA = 7'd40, S_VSTP = 7'd41,
    S_VFMT = 7'd42, S_CDP = 7'd43, S_CDESC = 7'd44, S_CLOC = 7'd45, S_CLT = 7'd46,
    S_CLB = 7'd47, S_TIMP = 7'd48, S_NUT = 7'd49, S_TS = 7'd50, S_FIXED = 7'd51,
    L_FMB = 7'd52, L_STYPE = 7'd53, L_PPS = 7'd54, L_CPID = 7'd55, L_FNUM = 7'd56,
    L_FPF = 7'd57, L_BOT = 7'd58;

  logic [6:0]  phase_q, phase_d;
  logic        isue_q, isue_d, sfx_q, sfx_d, zact_q, zact_d;
  logic [5:0]  left_q, left_d, zeros_q, zeros_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  bits_q, bits_d;
  logic        end_q, end_d, end_aud_q, end_aud_d;
  hnip_pkg::hnip_mode_e end_mode_q, end_mode_d;
  logic [5:0]  fnb_q, fnb_d;
  logic        sep_q, sep_d, field_q, field_d, ilace_q, ilace_d;
  logic [7:0]  sclast_q, sclast_d, profile_q, profile_d, aridc_q, aridc_d;
  logic [3:0]  sclist_q, sclist_d;
  logic [6:0]  sclpos_q, sclpos_d;
  logic        fmo_q, fmo_d, poc2_q, poc2_d, rok_q, rok_d;
  logic [31:0] loop_q, loop_d, nut_q, nut_d, rate_q, rate_d;
  logic [15:0] wid_q, wid_d, hgt_q, hgt_d, hmb_q, hmb_d, crop_q, crop_d;
  logic [15:0] sarw_q, sarw_d, sarh_q, sarh_d;
  logic        dbusy_q, dbusy_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic        oval_q, oval_d;
  hnip_pkg::hnip_result_t out_q, out_d;

  logic        out_free, feed, b, fin, st, st_ue, res_load, ge, dsub_ok;
  logic [6:0]  st_ph;
  logic [5:0]  st_n;
  logic [31:0] v, ll, q, acc_n;
  logic [32:0] sh;
  logic [31:0] r32, half;
  logic [7:0]  scnext;
  logic [16:0] csum;
  logic [15:0] an, ad;

  assign out_free = !oval_q || res_o.ready;

  function automatic logic [31:0] rate_of(input logic [31:0] qv, input logic fm,
                                           input logic p2);
    logic [31:0] r;
    if (fm || !p2) r = qv;
    else if (qv[31]) r = '1;
    else r = {qv[30:0], 1'b0};
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q; isue_d = isue_q; sfx_d = sfx_q; zact_d = zact_q;
    left_d = left_q; zeros_d = zeros_q; acc_d = acc_q; byte_d = byte_q; bits_d = bits_q;
    end_d = end_q; end_aud_d = end_aud_q; end_mode_d = end_mode_q;
    fnb_d = fnb_q; sep_d = sep_q; field_d = field_q; ilace_d = ilace_q;
    sclast_d = sclast_q; profile_d = profile_q; aridc_d = aridc_q; sclist_d = sclist_q;
    sclpos_d = sclpos_q; fmo_d = fmo_q; poc2_d = poc2_q; rok_d = rok_q;
    loop_d = loop_q; nut_d = nut_q; rate_d = rate_q; wid_d = wid_q; hgt_d = hgt_q;
    hmb_d = hmb_q; crop_d = crop_q; sarw_d = sarw_q; sarh_d = sarh_q;
    dbusy_d = dbusy_q; dcnt_d = dcnt_q; rem_d = rem_q; quo_d = quo_q;
    oval_d = oval_q && !res_o.ready; out_d = out_q;
    pop_o = 1'b0; feed = 1'b0; b = 1'b0; fin = 1'b0; v = '0; ll = loop_q;
    st = 1'b0; st_ue = 1'b0; st_ph = P_DONE; st_n = '0; res_load = 1'b0;
    sh = '0; ge = 1'b0; q = '0; acc_n = '0; r32 = '0; half = '0; scnext = '0;
    csum = '0; an = '0; ad = '0; dsub_ok = 1'b0;

    if (dbusy_q) begin
      sh     = {rem_q, quo_q[31]};
      ge     = (sh >= {1'b0, nut_q});
      rem_d  = ge ? 32'(sh - {1'b0, nut_q}) : sh[31:0];
      quo_d  = {quo_q[30:0], ge};
      dcnt_d = dcnt_q + 5'd1;
      if (dcnt_q == 5'd31) begin
        dbusy_d = 1'b0;
        rate_d  = rate_of(quo_d, fmo_q, poc2_q);
      end
    end else if (zact_q) begin
      zact_d = 1'b0;
      fin    = 1'b1;
    end else if (bits_q != 4'd0) begin
      byte_d = {byte_q[6:0], 1'b0};
      if (phase_q > P_DONE) begin
        feed   = 1'b1;
        b      = byte_q[7];
        bits_d = bits_q - 4'd1;
      end else begin
        bits_d = '0;
      end
    end else if (end_q) begin
      if ((end_mode_q == hnip_pkg::MODE_SLICE || end_mode_q == hnip_pkg::MODE_SPS)
          && phase_q > P_DONE) begin
        feed = 1'b1;
        b    = 1'b1;
        if (phase_q == S_CYC && loop_q > 32'd1) ll = 32'd1;
        loop_d = ll;
      end else if (out_free) begin
        res_load = 1'b1;
        end_d    = 1'b0;
        phase_d  = P_IDLE;
      end
    end else if (!empty_i) begin
      pop_o      = 1'b1;
      end_d      = entry_i.last;
      end_mode_d = entry_i.mode;
      end_aud_d  = entry_i.aud_intra;
      unique case (entry_i.kind)
        hnip_pkg::KIND_DATA: begin
          byte_d = entry_i.data;
          bits_d = 4'd8;
        end
        hnip_pkg::KIND_HDR: begin
          st = 1'b1;
          if (entry_i.mode == hnip_pkg::MODE_SPS) begin
            aridc_d = '0; rate_d = '0; rok_d = 1'b0; wid_d = '0; hgt_d = '0;
            fmo_d = 1'b0; poc2_d = 1'b0;
            st_ph = S_PROFILE; st_n = 6'd8;
          end else begin
            st_ph = L_FMB; st_ue = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (feed) begin
      if (!isue_q) begin
        acc_n  = {acc_q[30:0], b};
        acc_d  = acc_n;
        left_d = (left_q != 6'd0) ? left_q - 6'd1 : 6'd0;
        fin    = (left_d == 6'd0);
        v      = acc_n;
      end else if (!sfx_q) begin
        if (!b && zeros_q < 6'd32) begin
          zeros_d = zeros_q + 6'd1;
        end else if (zeros_q == 6'd0) begin
          fin = 1'b1;
        end else begin
          sfx_d  = 1'b1;
          left_d = zeros_q;
          acc_d  = '0;
        end
      end else begin
        acc_n  = {acc_q[30:0], b};
        acc_d  = acc_n;
        left_d = left_q - 6'd1;
        fin    = (left_d == 6'd0);
        v      = (32'd1 << zeros_q) - 32'd1 + acc_n;
      end
    end

    if (fin) begin
      unique case (phase_q)
        S_PROFILE: begin profile_d = v[7:0]; st = 1'b1; st_ph = S_CONSTR; st_n = 6'd8; end
        S_CONSTR:  begin st = 1'b1; st_ph = S_LEVEL; st_n = 6'd8; end
        S_LEVEL:   begin st = 1'b1; st_ph = S_SPSID; st_ue = 1'b1; end
        S_SPSID: begin
          sep_d = 1'b0; st = 1'b1; st_ue = 1'b1;
          if (profile_q == hnip_pkg::PROF_HIGH || profile_q == hnip_pkg::PROF_HIGH10 ||
              profile_q == hnip_pkg::PROF_HIGH422 || profile_q == hnip_pkg::PROF_HIGH444 ||
              profile_q == hnip_pkg::PROF_CAVLC444 || profile_q == hnip_pkg::PROF_SCALABLE ||
              profile_q == hnip_pkg::PROF_SCAL_HIGH) st_ph = S_CHROMA;
          else st_ph = S_LOG2;
        end
        S_CHROMA: begin
          st = 1'b1;
          if (v == 32'd3) begin st_ph = S_SEPF; st_n = 6'd1; end
          else begin st_ph = S_BDL; st_ue = 1'b1; end
        end
        S_SEPF: begin sep_d = v[0]; st = 1'b1; st_ph = S_BDL; st_ue = 1'b1; end
        S_BDL:  begin st = 1'b1; st_ph = S_BDC; st_ue = 1'b1; end
        S_BDC:  begin st = 1'b1; st_ph = S_QPB; st_n = 6'd1; end
        S_QPB:  begin st = 1'b1; st_ph = S_SMPF; st_n = 6'd1; end
        S_SMPF: begin
          st = 1'b1;
          if (v != 32'd0) begin sclist_d = '0; st_ph = S_SLPF; st_n = 6'd1; end
          else begin st_ph = S_LOG2; st_ue = 1'b1; end
        end
        S_SLPF: begin
          st = 1'b1;
          if (v != 32'd0) begin
            sclast_d = 8'd8; sclpos_d = '0; st_ph = S_DELTA; st_ue = 1'b1;
          end else begin
            sclist_d = sclist_q + 4'd1;
            if (sclist_d < 4'd8) begin st_ph = S_SLPF; st_n = 6'd1; end
            else begin st_ph = S_LOG2; st_ue = 1'b1; end
          end
        end
        S_DELTA: begin
          r32    = v + 32'd1;
          half   = r32 >> 1;
          scnext = r32[0] ? (sclast_q - half[7:0]) : (sclast_q + half[7:0]);
          if (scnext != 8'd0) sclast_d = scnext;
          sclpos_d = sclpos_q + 7'd1;
          st = 1'b1;
          if (sclpos_d < ((sclist_q < 4'd6) ? 7'd16 : 7'd64) && scnext != 8'd0) begin
            st_ph = S_DELTA; st_ue = 1'b1;
          end else begin
            sclist_d = sclist_q + 4'd1;
            if (sclist_d < 4'd8) begin st_ph = S_SLPF; st_n = 6'd1; end
            else begin st_ph = S_LOG2; st_ue = 1'b1; end
          end
        end
        S_LOG2: begin fnb_d = v[5:0] + 6'd4; st = 1'b1; st_ph = S_POCT; st_ue = 1'b1; end
        S_POCT: begin
          poc2_d = (v == 32'd2); st = 1'b1;
          if (v == 32'd0) begin st_ph = S_POCLSB; st_ue = 1'b1; end
          else if (v == 32'd1) begin st_ph = S_DPAZ; st_n = 6'd1; end
          else begin st_ph = S_NREF; st_ue = 1'b1; end
        end
        S_POCLSB: begin st = 1'b1; st_ph = S_NREF; st_ue = 1'b1; end
        S_DPAZ:   begin st = 1'b1; st_ph = S_OFF1; st_ue = 1'b1; end
        S_OFF1:   begin st = 1'b1; st_ph = S_OFF2; st_ue = 1'b1; end
        S_OFF2:   begin st = 1'b1; st_ph = S_NCYC; st_ue = 1'b1; end
        S_NCYC: begin
          loop_d = v; st = 1'b1; st_ue = 1'b1;
          st_ph = (v != 32'd0) ? S_CYC : S_NREF;
        end
        S_CYC: begin
          loop_d = ll - 32'd1; st = 1'b1; st_ue = 1'b1;
          st_ph = (loop_d != 32'd0) ? S_CYC : S_NREF;
        end
        S_NREF:   begin st = 1'b1; st_ph = S_GAPS; st_n = 6'd1; end
        S_GAPS:   begin st = 1'b1; st_ph = S_WIDTH; st_ue = 1'b1; end
        S_WIDTH: begin
          wid_d = {v[11:0] + 12'd1, 4'd0}; st = 1'b1; st_ph = S_HEIGHT; st_ue = 1'b1;
        end
        S_HEIGHT: begin hmb_d = v[15:0] + 16'd1; st = 1'b1; st_ph = S_FMO; st_n = 6'd1; end
        S_FMO: begin
          fmo_d = v[0];
          hgt_d = v[0] ? {hmb_q[11:0], 4'd0} : {hmb_q[10:0], 5'd0};
          st = 1'b1; st_n = 6'd1;
          st_ph = v[0] ? S_D8 : S_MBAFF;
        end
        S_MBAFF: begin st = 1'b1; st_ph = S_D8; st_n = 6'd1; end
        S_D8:    begin st = 1'b1; st_ph = S_CROPF; st_n = 6'd1; end
        S_CROPF: begin
          st = 1'b1;
          if (v != 32'd0) begin st_ph = S_CL; st_ue = 1'b1; end
          else begin st_ph = S_VUIF; st_n = 6'd1; end
        end
        S_CL: begin crop_d = v[15:0]; st = 1'b1; st_ph = S_CR; st_ue = 1'b1; end
        S_CR: begin
          csum  = {1'b0, crop_q} + {1'b0, v[15:0]};
          wid_d = wid_q - {csum[14:0], 1'b0};
          st = 1'b1; st_ph = S_CT; st_ue = 1'b1;
        end
        S_CT: begin crop_d = v[15:0]; st = 1'b1; st_ph = S_CB; st_ue = 1'b1; end
        S_CB: begin
          csum  = {1'b0, crop_q} + {1'b0, v[15:0]};
          hgt_d = hgt_q - (fmo_q ? {csum[14:0], 1'b0} : {csum[13:0], 2'b0});
          st = 1'b1; st_ph = S_VUIF; st_n = 6'd1;
        end
        S_VUIF: begin
          if (v != 32'd0) begin st = 1'b1; st_ph = S_ARP; st_n = 6'd1; end
          else phase_d = P_DONE;
        end
        S_ARP: begin
          st = 1'b1;
          if (v != 32'd0) begin st_ph = S_ARIDC; st_n = 6'd8; end
          else begin st_ph = S_OVSP; st_n = 6'd1; end
        end
        S_ARIDC: begin
          aridc_d = v[7:0]; st = 1'b1;
          if (v == 32'(hnip_pkg::AR_EXTENDED)) begin st_ph = S_SARW; st_n = 6'd16; end
          else begin st_ph = S_OVSP; st_n = 6'd1; end
        end
        S_SARW: begin sarw_d = v[15:0]; st = 1'b1; st_ph = S_SARH; st_n = 6'd16; end
        S_SARH: begin sarh_d = v[15:0]; st = 1'b1; st_ph = S_OVSP; st_n = 6'd1; end
        S_OVSP: begin
          st = 1'b1; st_n = 6'd1; st_ph = (v != 32'd0) ? S_OVSA : S_VSTP;
        end
        S_OVSA: begin st = 1'b1; st_ph = S_VSTP; st_n = 6'd1; end
        S_VSTP: begin
          st = 1'b1;
          if (v != 32'd0) begin st_ph = S_VFMT; st_n = 6'd4; end
          else begin st_ph = S_CLOC; st_n = 6'd1; end
        end
        S_VFMT: begin st = 1'b1; st_ph = S_CDP; st_n = 6'd1; end
        S_CDP: begin
          st = 1'b1;
          if (v != 32'd0) begin st_ph = S_CDESC; st_n = 6'd24; end
          else begin st_ph = S_CLOC; st_n = 6'd1; end
        end
        S_CDESC: begin st = 1'b1; st_ph = S_CLOC; st_n = 6'd1; end
        S_CLOC: begin
          st = 1'b1;
          if (v != 32'd0) begin st_ph = S_CLT; st_ue = 1'b1; end
          else begin st_ph = S_TIMP; st_n = 6'd1; end
        end
        S_CLT: begin st = 1'b1; st_ph = S_CLB; st_ue = 1'b1; end
        S_CLB: begin st = 1'b1; st_ph = S_TIMP; st_n = 6'd1; end
        S_TIMP: begin
          if (v != 32'd0) begin st = 1'b1; st_ph = S_NUT; st_n = 6'd32; end
          else phase_d = P_DONE;
        end
        S_NUT: begin nut_d = v; st = 1'b1; st_ph = S_TS; st_n = 6'd32; end
        S_TS: begin
          dsub_ok = (nut_q != 32'd0);
          if (dsub_ok) begin
            dbusy_d = 1'b1; dcnt_d = '0; rem_d = '0; quo_d = v;
          end else begin
            rate_d = rate_of(q, fmo_q, poc2_q);
          end
          st = 1'b1; st_ph = S_FIXED; st_n = 6'd1;
        end
        S_FIXED: begin
          rok_d = (v != 32'd0) && (rate_q != 32'd0);
          if (!rok_d) rate_d = '0;
          phase_d = P_DONE;
        end
        L_FMB:   begin st = 1'b1; st_ph = L_STYPE; st_ue = 1'b1; end
        L_STYPE: begin st = 1'b1; st_ph = L_PPS; st_ue = 1'b1; end
        L_PPS: begin
          st = 1'b1;
          if (sep_q) begin st_ph = L_CPID; st_n = 6'd2; end
          else begin st_ph = L_FNUM; st_n = fnb_q; end
        end
        L_CPID: begin st = 1'b1; st_ph = L_FNUM; st_n = fnb_q; end
        L_FNUM: begin
          if (ilace_q) begin st = 1'b1; st_ph = L_FPF; st_n = 6'd1; end
          else phase_d = P_DONE;
        end
        L_FPF: begin
          if (v != 32'd0) begin st = 1'b1; st_ph = L_BOT; st_n = 6'd1; end
          else begin field_d = 1'b1; phase_d = P_DONE; end
        end
        L_BOT: begin field_d = v[0]; phase_d = P_DONE; end
        default: phase_d = P_DONE;
      endcase
      zact_d = st && !st_ue && (st_n == 6'd0);
    end

    if (st) begin
      phase_d = st_ph; isue_d = st_ue; left_d = st_n;
      zeros_d = '0; sfx_d = 1'b0; acc_d = '0;
    end

    if (res_load) begin
      oval_d = 1'b1;
      out_d  = '0;
      if (end_mode_q == hnip_pkg::MODE_AUD) begin
        if (end_aud_q) begin
          out_d.frame_start = 1'b1; out_d.intra_picture = 1'b1; field_d = 1'b0;
        end else begin
          out_d.frame_start = ilace_q ? field_q : 1'b1;
        end
      end else if (end_mode_q == hnip_pkg::MODE_SPS) begin
        ilace_d = !fmo_q;
        if (aridc_q >= 8'd1 && aridc_q <= 8'd16) begin
          out_d.aspect_updated = 1'b1;
          an = {8'd0, hnip_pkg::sar_num(aridc_q[4:0])};
          ad = {8'd0, hnip_pkg::sar_den(aridc_q[4:0])};
          if (aridc_q == 8'd1) begin
            if (hgt_q == hnip_pkg::RES_1080 && wid_q == hnip_pkg::RES_1920) begin
              an = 16'd16; ad = 16'd9;
            end
            if (hgt_q == hnip_pkg::RES_720 && wid_q == hnip_pkg::RES_960) begin
              an = 16'd4; ad = 16'd3;
            end
            if (hgt_q == hnip_pkg::RES_720 && wid_q == hnip_pkg::RES_1280) begin
              an = 16'd16; ad = 16'd9;
            end
          end
        end else if (aridc_q == hnip_pkg::AR_EXTENDED) begin
          out_d.aspect_updated = 1'b1; an = sarw_q; ad = sarh_q;
        end
        out_d.sps_updated   = 1'b1;
        out_d.pic_width     = wid_q;
        out_d.pic_height    = hgt_q;
        out_d.aspect_num    = an;
        out_d.aspect_den    = ad;
        out_d.rate_updated  = rok_q;
        out_d.frame_rate_x2 = rate_q;
      end
      out_d.interlaced = ilace_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; isue_q <= 1'b0; sfx_q <= 1'b0; zact_q <= 1'b0;
      left_q <= '0; zeros_q <= '0; acc_q <= '0; bits_q <= '0;
      end_q <= 1'b0; end_aud_q <= 1'b0; end_mode_q <= hnip_pkg::MODE_NONE;
      fnb_q <= '0; sep_q <= 1'b0; field_q <= 1'b0; ilace_q <= 1'b0; sclast_q <= 8'd8;
      profile_q <= '0; aridc_q <= '0; sclist_q <= '0; sclpos_q <= '0;
      fmo_q <= 1'b0; poc2_q <= 1'b0; rok_q <= 1'b0; loop_q <= '0; nut_q <= '0;
      rate_q <= '0; wid_q <= '0; hgt_q <= '0; hmb_q <= '0; crop_q <= '0;
      sarw_q <= '0; sarh_q <= '0; dbusy_q <= 1'b0; dcnt_q <= '0; oval_q <= 1'b0;
    end else begin
      phase_q <= phase_d; isue_q <= isue_d; sfx_q <= sfx_d; zact_q <= zact_d;
      left_q <= left_d; zeros_q <= zeros_d; acc_q <= acc_d; bits_q <= bits_d;
      end_q <= end_d; end_aud_q <= end_aud_d; end_mode_q <= end_mode_d;
      fnb_q <= fnb_d; sep_q <= sep_d; field_q <= field_d; ilace_q <= ilace_d;
      sclast_q <= sclast_d; profile_q <= profile_d; aridc_q <= aridc_d;
      sclist_q <= sclist_d; sclpos_q <= sclpos_d; fmo_q <= fmo_d; poc2_q <= poc2_d;
      rok_q <= rok_d; loop_q <= loop_d; nut_q <= nut_d; rate_q <= rate_d;
      wid_q <= wid_d; hgt_q <= hgt_d; hmb_q <= hmb_d; crop_q <= crop_d;
      sarw_q <= sarw_d; sarh_q <= sarh_d; dbusy_q <= dbusy_d; dcnt_q <= dcnt_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    out_q  <= out_d;
  end

  assign res_o.valid          = oval_q;
  assign res_o.frame_start    = out_q.frame_start;
  assign res_o.intra_picture  = out_q.intra_picture;
  assign res_o.sps_updated    = out_q.sps_updated;
  assign res_o.interlaced     = out_q.interlaced;
  assign res_o.pic_width      = out_q.pic_width;
  assign res_o.pic_height     = out_q.pic_height;
  assign res_o.aspect_updated = out_q.aspect_updated;
  assign res_o.aspect_num     = out_q.aspect_num;
  assign res_o.aspect_den     = out_q.aspect_den;
  assign res_o.rate_updated   = out_q.rate_updated;
  assign res_o.frame_rate_x2  = out_q.frame_rate_x2;

  a_div_holds_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |=> $stable(bits_q) && $stable(phase_q))
    else $error("bit stream advanced during division");

  a_zact_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zact_q |-> (phase_q > P_DONE) && !isue_q && (left_q == 6'd0))
    else $error("zero-length read pending outside a fixed field");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (phase_q == P_IDLE) && oval_q && !end_q)
    else $error("result issued without closing the packet");

  a_zero_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    isue_q && !sfx_q |-> zeros_q <= 6'd32)
    else $error("leading-zero run beyond cap");

endmodule

### rtl/core/h264_nal_header_info_parser_top.sv
// ----------------------------------------------------------------------------
// h264_nal_header_info_parser_top
// H.264 NAL header parser: delimiters, slice field parity, SPS picture info.
// ----------------------------------------------------------------------------
// Input channel pkt_i carries one packet byte per request, start code first,
// with first_of_packet on the opening byte and last_of_packet on the closing
// one. Each closed packet yields one request on res_o.
// Every byte (start code, header, delimiter or payload) is taken by the
// framing stage at one byte per cycle while the queue is not full. Slice and
// SPS payload bytes go through a four-entry queue to the bit parser, which
// pops a byte and takes one bit per cycle, pausing while the divider runs.
// After the last byte the parser completes its syntax walk on implied one
// bits, and a timing SPS also runs the serial rate divider. The result then
// sits in an output register; the parser waits to load the next result while
// that register still holds one not yet taken.
// pkt_i.ready drops while the queue is full.
// Reset clears the parser state, the field parity, the interlace mode and
// any result not yet taken.
// ----------------------------------------------------------------------------
module h264_nal_header_info_parser_top #(
  parameter int unsigned PrefixBytes = hnip_pkg::PREFIX_BYTES_DEF,
  parameter int unsigned FifoDepth   = hnip_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hnip_in_if.sink    pkt_i,
  hnip_out_if.source res_o
);

  hnip_pkg::hnip_entry_t wentry, rentry;
  logic                  push, full, pop, empty;

  hnip_front #(.PrefixBytes(PrefixBytes)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pkt_i   (pkt_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (wentry)
  );

  hnip_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rentry),
    .empty_o (empty)
  );

  hnip_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (rentry),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
